FILE: hw/rtl/integer_execute_unit_assert.svh
// Assertion macros used by the integer execute unit RTL.
// No dependencies; the assertion forms drop out when SYNTH is defined.
`ifndef INTEGER_EXECUTE_UNIT_ASSERT_SVH
`define INTEGER_EXECUTE_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define IEU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define IEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IEU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define IEU_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/ieu_pkg.sv
// Shared constants and the operation code type of the integer execute unit.
// No dependencies.
package ieu_pkg;

  localparam int DEF_REG_COUNT = 32;
  localparam int DATA_W        = 32;
  localparam int REG_IDX_W     = 5;
  localparam int OP_W          = 4;
  localparam int WORD_SHIFT    = 2;

  localparam logic [REG_IDX_W-1:0] LINK_REG = 5'd31;

  typedef enum logic [OP_W-1:0] {
    OP_ADDI = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_BEQZ = 4'd5,
    OP_BNEZ = 4'd6,
    OP_JAL  = 4'd7,
    OP_JR   = 4'd8
  } op_t;

endpackage

FILE: hw/rtl/ieu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ieu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ieu_div.sv
// Signed truncating divider, restoring, one quotient bit per cycle.
// Depends on ieu_pkg for the default data width.
module ieu_div
  import ieu_pkg::*;
#(
  parameter int WIDTH = DATA_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic             busy;
  logic             fix;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] mag_b;
  logic             neg;

  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   diff;

  // The partial remainder stays below the divisor magnitude, so the shifted
  // value fits one extra bit and the borrow of diff decides the quotient bit.
  assign rem_sh = {rem, quo[WIDTH-1]};
  assign diff   = rem_sh - {1'b0, mag_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      // Done pulses in the cycle after the sign fix-up.
      done <= !start && !busy && fix;
      if (start) begin
        rem   <= '0;
        quo   <= dividend[WIDTH-1] ? (WIDTH'(0) - dividend) : dividend;
        mag_b <= divisor[WIDTH-1] ? (WIDTH'(0) - divisor) : divisor;
        neg   <= dividend[WIDTH-1] ^ divisor[WIDTH-1];
        cnt   <= CNT_W'(WIDTH);
        busy  <= 1'b1;
      end else if (busy) begin
        if (!diff[WIDTH]) begin
          rem <= diff[WIDTH-1:0];
          quo <= {quo[WIDTH-2:0], 1'b1};
        end else begin
          rem <= rem_sh[WIDTH-1:0];
          quo <= {quo[WIDTH-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        quotient <= neg ? (WIDTH'(0) - quo) : quo;
        fix      <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/integer_execute_unit.sv
// Integer execute unit: one instruction per transaction against a register file RAM.
// Depends on ieu_pkg, ieu_ram, ieu_div and integer_execute_unit_assert.svh.
// A new instruction is accepted only in S_IDLE, after the previous result has moved to the
// output register; the three operand reads share the single RAM read port and the divider
// retires one bit per cycle.
// Reset (rst, synchronous, active high) empties both channels and marks every register zero.
`include "integer_execute_unit_assert.svh"

module integer_execute_unit
  import ieu_pkg::*;
#(
  parameter int REG_COUNT = DEF_REG_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  // Input instruction stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits from 0 up: reg_x[4:0], reg_y[9:5], reg_z[14:10], immediate[46:15],
  // current_pc[78:47], zero pad [79].
  input  logic [79:0] s_axis_tdata,
  // Bits from 0 up: req_type[3:0].
  input  logic [3:0]  s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits from 0 up: new_pc[31:0], write_enable[32], write_index[37:33],
  // write_value[69:38], divide_by_zero[70], zero pad [71].
  output logic [71:0] m_axis_tdata
);

  localparam int IDX_W = $clog2(REG_COUNT);

  // The instruction walks through the states in order: the three operand
  // reads are issued one per cycle, each read word is captured in the next
  // state, then the operation executes, a divide with a nonzero divisor
  // waits in S_DIV, and the result waits in S_DONE for a free output register.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_Y,
    S_RD_Z,
    S_RD_X,
    S_CAP_X,
    S_EXEC,
    S_DIV,
    S_DONE
  } state_t;

  state_t                state;

  // Latched instruction.
  op_t                   op;
  logic [REG_IDX_W-1:0]  rx;
  logic [REG_IDX_W-1:0]  ry;
  logic [REG_IDX_W-1:0]  rz;
  logic [DATA_W-1:0]     imm;
  logic [DATA_W-1:0]     pc;

  // Operand values.
  logic [DATA_W-1:0]     vx;
  logic [DATA_W-1:0]     vy;
  logic [DATA_W-1:0]     vz;

  // Result held until the output register takes it.
  logic [DATA_W-1:0]     res_pc;
  logic                  res_we;
  logic [REG_IDX_W-1:0]  res_idx;
  logic [DATA_W-1:0]     res_val;
  logic                  res_dz;

  // Register file. The RAM has no reset; a per-entry written flag, cleared
  // by reset, makes an unwritten register read as zero.
  logic [REG_COUNT-1:0]  written;
  logic                  rd_written;
  logic [IDX_W-1:0]      ram_raddr;
  logic [DATA_W-1:0]     ram_rdata;
  logic                  ram_we;
  logic [DATA_W-1:0]     rd_word;

  logic                  out_free;

  // Execute stage.
  logic [DATA_W-1:0]     exec_pc;
  logic                  exec_we;
  logic [REG_IDX_W-1:0]  exec_idx;
  logic [DATA_W-1:0]     exec_val;
  logic                  exec_dz;
  logic [DATA_W-1:0]     product;
  logic [DATA_W-1:0]     branch_pc;

  // Divider handshake.
  logic                  div_start;
  logic                  div_done;
  logic [DATA_W-1:0]     div_quot;

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign rd_word       = rd_written ? ram_rdata : '0;

  // The write-back happens in the same cycle the result moves to the output
  // register, so the next instruction always reads the updated file.
  assign ram_we = (state == S_DONE) && out_free && res_we;

  always_comb begin
    case (state)
      S_RD_Y:  ram_raddr = ry[IDX_W-1:0];
      S_RD_Z:  ram_raddr = rz[IDX_W-1:0];
      S_RD_X:  ram_raddr = rx[IDX_W-1:0];
      default: ram_raddr = rx[IDX_W-1:0];
    endcase
  end

  ieu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (REG_COUNT)
  ) u_regfile (
    .clk   (clk),
    .we    (ram_we),
    .waddr (res_idx[IDX_W-1:0]),
    .wdata (res_val),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ieu_div #(
    .WIDTH (DATA_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (vy),
    .divisor  (vz),
    .done     (div_done),
    .quotient (div_quot)
  );

  // The low word of the product is registered into res_val directly.
  assign product   = vy * vz;
  // Branch offsets count words.
  assign branch_pc = pc + {imm[DATA_W-1-WORD_SHIFT:0], {WORD_SHIFT{1'b0}}};

  always_comb begin
    exec_pc  = pc;
    exec_we  = 1'b0;
    exec_idx = '0;
    exec_val = '0;
    exec_dz  = 1'b0;
    case (op)
      OP_ADDI: begin
        exec_we  = 1'b1;
        exec_idx = rx;
        exec_val = vy + imm;
      end
      OP_ADD: begin
        exec_we  = 1'b1;
        exec_idx = rx;
        exec_val = vy + vz;
      end
      OP_SUB: begin
        exec_we  = 1'b1;
        exec_idx = rx;
        exec_val = vy - vz;
      end
      OP_MUL: begin
        exec_we  = 1'b1;
        exec_idx = rx;
        exec_val = product;
      end
      OP_DIV: begin
        // The quotient itself comes from the divider later; a zero divisor
        // writes zero and raises the flag.
        exec_we  = 1'b1;
        exec_idx = rx;
        exec_dz  = (vz == '0);
      end
      OP_BEQZ: begin
        if (vx == '0) begin
          exec_pc = branch_pc;
        end
      end
      OP_BNEZ: begin
        if (vx != '0) begin
          exec_pc = branch_pc;
        end
      end
      OP_JAL: begin
        exec_we  = 1'b1;
        exec_idx = LINK_REG;
        exec_val = pc;
        exec_pc  = pc + imm;
      end
      OP_JR: begin
        exec_pc = vx;
      end
      default: begin
        // Unused codes leave the counter and the register file alone.
        exec_pc = pc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      written       <= '0;
      div_start     <= 1'b0;
    end else begin
      // A divide with a nonzero divisor starts the divider as it leaves S_EXEC.
      div_start  <= (state == S_EXEC) && (op == OP_DIV) && !exec_dz;
      rd_written <= written[ram_raddr];
      // A result loaded in S_DONE replaces the one being accepted, so the
      // valid flag only drops when nothing new arrives.
      if (m_axis_tvalid && m_axis_tready && !((state == S_DONE) && out_free)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op    <= op_t'(s_axis_tuser[3:0]);
            rx    <= s_axis_tdata[4:0];
            ry    <= s_axis_tdata[9:5];
            rz    <= s_axis_tdata[14:10];
            imm   <= s_axis_tdata[46:15];
            pc    <= s_axis_tdata[78:47];
            state <= S_RD_Y;
          end
        end
        S_RD_Y: begin
          state <= S_RD_Z;
        end
        S_RD_Z: begin
          vy    <= rd_word;
          state <= S_RD_X;
        end
        S_RD_X: begin
          vz    <= rd_word;
          state <= S_CAP_X;
        end
        S_CAP_X: begin
          vx    <= rd_word;
          state <= S_EXEC;
        end
        S_EXEC: begin
          res_pc  <= exec_pc;
          res_we  <= exec_we;
          res_idx <= exec_idx;
          res_val <= exec_val;
          res_dz  <= exec_dz;
          if ((op == OP_DIV) && !exec_dz) begin
            state <= S_DIV;
          end else begin
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_val <= div_quot;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {1'b0, res_dz, res_val, res_idx, res_we, res_pc};
            if (res_we) begin
              written[res_idx[IDX_W-1:0]] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A zero divisor always reports a write of zero.
  `IEU_ASSERT_IMPLY(a_dz_writes_zero, clk, rst,
                    m_axis_tvalid && m_axis_tdata[70],
                    m_axis_tdata[32] && (m_axis_tdata[69:38] == '0),
                    "divide by zero result must write zero")
  // A result without a register write carries zero index and value.
  `IEU_ASSERT_IMPLY(a_no_write_clean, clk, rst,
                    m_axis_tvalid && !m_axis_tdata[32],
                    (m_axis_tdata[37:33] == '0) && (m_axis_tdata[69:38] == '0),
                    "result without write must have zero index and value")
  // The divider only finishes while the sequencer waits for it.
  `IEU_ASSERT_IMPLY(a_div_done_in_div, clk, rst, div_done, state == S_DIV,
                    "divider finished outside of divide wait")
  // Handing a result to the output register always frees the sequencer.
  `IEU_ASSERT_NEXT(a_done_to_out, clk, rst, (state == S_DONE) && out_free,
                   m_axis_tvalid && (state == S_IDLE),
                   "result hand-off did not reach the output")

endmodule
